// ----- rtl/aau_pkg.sv -----
// ----------------------------------------------------------------------------
// Annealing acceptance unit package
// Shared widths, register indexes, word types and the constant functions that
// build the exponential table at elaboration.
// ----------------------------------------------------------------------------
package aau_pkg;

  localparam int COST_BITS       = 16;
  localparam int RND_BITS        = 16;
  localparam int TEMP_BITS       = 32;
  localparam int COOL_BITS       = 16;
  localparam int EXP_BITS        = 17;
  localparam int EXP_TABLE_DEPTH = 256;
  localparam int EXP_RANGE       = 16;
  localparam int INDEX_SHIFT     = 12;
  localparam int CFG_INDEX_BITS  = 1;
  localparam int CFG_DATA_BITS   = 32;

  localparam logic [TEMP_BITS-1:0] INIT_TEMP_RESET = 32'd6553600;
  localparam logic [COOL_BITS-1:0] COOLING_RESET   = 16'd64880;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_INITIAL_TEMPERATURE = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_COOLING_FACTOR      = 1'b1;

  localparam logic [63:0] ONE_Q32  = 64'h0000_0001_0000_0000;
  localparam logic [63:0] HALF_Q32 = 64'h0000_0000_8000_0000;
  localparam logic [63:0] FRAC_MASK = 64'h0000_0000_FFFF_FFFF;
  localparam logic [63:0] ROUND_Q16 = 64'h0000_0000_0000_8000;

  typedef enum logic {
    OP_START     = 1'b0,
    OP_CANDIDATE = 1'b1
  } op_e;

  typedef struct packed {
    op_e                  op;
    logic [COST_BITS-1:0] cost;
    logic [RND_BITS-1:0]  random_fraction;
  } in_word_t;

  typedef struct packed {
    logic                 accepted;
    logic                 new_best;
    logic [COST_BITS-1:0] current_cost_out;
    logic [COST_BITS-1:0] best_cost_out;
    logic [TEMP_BITS-1:0] temperature_out;
    logic                 solved;
  } out_word_t;

  // e^-f for a Q0.32 fraction, by a truncated 20-term series, clamped to [0, 1.0].
  function automatic logic [63:0] exp_neg_frac(input logic [63:0] f);
    longint      sum;
    logic [63:0] term;
    sum  = longint'(ONE_Q32);
    term = ONE_Q32;
    for (int k = 1; k <= 20; k++) begin
      term = ((term * f) >> 32) / 64'(k);
      if (k[0]) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > longint'(ONE_Q32)) begin
      sum = longint'(ONE_Q32);
    end
    return 64'(sum);
  endfunction

  // One table entry: e^-arg for a Q32.32 argument, rounded to Q1.16.
  function automatic logic [EXP_BITS-1:0] exp_entry(input logic [63:0] arg);
    logic [63:0] half;
    logic [63:0] em1;
    logic [63:0] whole;
    logic [63:0] v;
    half  = exp_neg_frac(HALF_Q32);
    em1   = (half * half) >> 32;
    whole = arg >> 32;
    v     = exp_neg_frac(arg & FRAC_MASK);
    for (int n = 0; n < EXP_RANGE; n++) begin
      if (64'(n) < whole) begin
        v = (v * em1) >> 32;
      end
    end
    return EXP_BITS'((v + ROUND_Q16) >> 16);
  endfunction

endpackage

// ----- rtl/annealing_acceptance_unit.sv -----
// ----------------------------------------------------------------------------
// Annealing acceptance unit
// Metropolis acceptance test with geometric cooling for simulated annealing.
//
// A start word (op = 0) loads its cost as current and best cost and loads the
// temperature from the initial_temperature register. A candidate word first
// cools the temperature, then accepts a lower or equal cost outright, and a
// higher cost when the table value of exp(-delta/T) beats random_fraction.
// Every input word gives exactly one output word on the output channel.
// Cooling runs on a bit-serial shift-add multiplier, and delta/T runs on a
// restoring divider, one quotient bit per cycle. One word is in work at a
// time; the next one is taken in the cycle after the result moves to the
// output register. The output register lets the core take a new word while
// a result waits; a stalled result holds, and a finished core waits for the
// register to free. Reset gives current cost 0, best cost all ones,
// temperature 0, not solved, and the register defaults. The user must see
// that registers are written only while idle; the block itself does not
// enforce it.
// ----------------------------------------------------------------------------
module annealing_acceptance_unit #(
  parameter int EXP_TABLE_DEPTH = aau_pkg::EXP_TABLE_DEPTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  aau_pkg::in_word_t                   in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output aau_pkg::out_word_t                  out_data_o,
  input  logic                                cfg_we_i,
  input  logic [aau_pkg::CFG_INDEX_BITS-1:0]  cfg_index_i,
  input  logic [aau_pkg::CFG_DATA_BITS-1:0]   cfg_data_i
);

  localparam int CostBits  = aau_pkg::COST_BITS;
  localparam int TempBits  = aau_pkg::TEMP_BITS;
  localparam int CoolBits  = aau_pkg::COOL_BITS;
  localparam int ExpBits   = aau_pkg::EXP_BITS;
  localparam int IdxBits   = $clog2(EXP_TABLE_DEPTH);
  localparam int RomDepth  = 2 ** IdxBits;
  localparam int MulSteps  = CoolBits;
  localparam int CntBits   = $clog2((MulSteps > IdxBits) ? MulSteps : IdxBits);
  localparam int ProdBits  = TempBits + CoolBits;
  localparam int ShBits    = CostBits + aau_pkg::INDEX_SHIFT;
  localparam int WideBits  = (ShBits > TempBits) ? ShBits : TempBits;
  localparam int ScaleBits = TempBits + IdxBits;

  localparam int StateBits = 3;
  localparam logic [StateBits-1:0] ST_IDLE  = 3'd0;
  localparam logic [StateBits-1:0] ST_MUL   = 3'd1;
  localparam logic [StateBits-1:0] ST_CMP   = 3'd2;
  localparam logic [StateBits-1:0] ST_SCALE = 3'd3;
  localparam logic [StateBits-1:0] ST_DIV   = 3'd4;
  localparam logic [StateBits-1:0] ST_LOOK  = 3'd5;
  localparam logic [StateBits-1:0] ST_FIN   = 3'd6;

  // Exponential table, built at elaboration; entries past the depth are unused.
  logic [ExpBits-1:0] exp_rom [RomDepth];

  for (genvar g = 0; g < RomDepth; g++) begin : g_rom
    if (g < EXP_TABLE_DEPTH) begin : g_entry
      localparam logic [63:0] ArgQ32 =
        ((64'(g) * 64'(aau_pkg::EXP_RANGE)) << 32) / 64'(EXP_TABLE_DEPTH);
      localparam logic [ExpBits-1:0] Entry = aau_pkg::exp_entry(ArgQ32);
      assign exp_rom[g] = Entry;
    end else begin : g_pad
      assign exp_rom[g] = '0;
    end
  end

  logic [StateBits-1:0] state_q, state_d;
  logic                 out_valid_q, out_valid_d;
  aau_pkg::out_word_t   out_q, out_d;
  logic [TempBits-1:0]  init_temp_q, init_temp_d;
  logic [CoolBits-1:0]  cool_q, cool_d;
  logic [CostBits-1:0]  cur_q, cur_d;
  logic [CostBits-1:0]  best_q, best_d;
  logic [TempBits-1:0]  temp_q, temp_d;
  logic                 solved_q, solved_d;

  aau_pkg::in_word_t    item_q, item_d;
  logic [ProdBits-1:0]  p_q, p_d;
  logic [CntBits-1:0]   cnt_q, cnt_d;
  logic [CostBits-1:0]  delta_q, delta_d;
  logic [TempBits-1:0]  rem_q, rem_d;
  logic [IdxBits-1:0]   lowx_q, lowx_d;
  logic [ExpBits-1:0]   rom_q, rom_d;
  logic                 acc_q, acc_d;
  logic                 use_rom_q, use_rom_d;

  // Multiplier step: add the temperature when the low multiplier bit is set.
  logic [TempBits:0]    mul_sum;
  logic [ProdBits-1:0]  mul_next;
  // Compare stage.
  logic                 cand_lower;
  logic [CostBits-1:0]  delta;
  logic [WideBits-1:0]  scaled_cmp;
  logic                 too_far;
  // Scale and divide.
  logic [WideBits-1:0]  scaled_reg;
  logic [ScaleBits-1:0] scale_prod;
  logic [TempBits:0]    div_trial;
  logic [TempBits:0]    div_diff;
  logic                 div_ge;
  // Final update.
  logic                 out_free;
  logic                 fin_start;
  logic                 fin_acc;
  logic [CostBits-1:0]  fin_cur;
  logic                 fin_improved;
  logic [CostBits-1:0]  fin_best;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  assign mul_sum  = {1'b0, p_q[ProdBits-1:CoolBits]} + (p_q[0] ? {1'b0, temp_q} : '0);
  assign mul_next = {mul_sum, p_q[CoolBits-1:1]};

  assign cand_lower = item_q.cost < cur_q;
  assign delta      = item_q.cost - cur_q;
  assign scaled_cmp = WideBits'({delta, {aau_pkg::INDEX_SHIFT{1'b0}}});
  assign too_far    = (temp_q == '0) || (scaled_cmp >= WideBits'(temp_q));

  // The scaled delta is below the temperature here, so its low word holds it all.
  assign scaled_reg = WideBits'({delta_q, {aau_pkg::INDEX_SHIFT{1'b0}}});
  assign scale_prod = ScaleBits'(scaled_reg[TempBits-1:0]) * ScaleBits'(EXP_TABLE_DEPTH);

  assign div_trial = {rem_q, lowx_q[IdxBits-1]};
  assign div_ge    = div_trial >= {1'b0, temp_q};
  assign div_diff  = div_trial - {1'b0, temp_q};

  assign fin_start    = (item_q.op == aau_pkg::OP_START);
  assign fin_acc      = !fin_start &&
                        (use_rom_q ? (rom_q > ExpBits'(item_q.random_fraction)) : acc_q);
  assign fin_cur      = (fin_start || fin_acc) ? item_q.cost : cur_q;
  assign fin_improved = !fin_start && (fin_cur < best_q);
  assign fin_best     = fin_start ? item_q.cost : (fin_improved ? fin_cur : best_q);

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    init_temp_d = init_temp_q;
    cool_d      = cool_q;
    cur_d       = cur_q;
    best_d      = best_q;
    temp_d      = temp_q;
    solved_d    = solved_q;
    item_d      = item_q;
    p_d         = p_q;
    cnt_d       = cnt_q;
    delta_d     = delta_q;
    rem_d       = rem_q;
    lowx_d      = lowx_q;
    rom_d       = rom_q;
    acc_d       = acc_q;
    use_rom_d   = use_rom_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          item_d  = in_data_i;
          p_d     = {{TempBits{1'b0}}, cool_q};
          cnt_d   = CntBits'(MulSteps - 1);
          state_d = (in_data_i.op == aau_pkg::OP_START) ? ST_FIN : ST_MUL;
        end
      end
      ST_MUL: begin
        p_d = mul_next;
        if (cnt_q == '0) begin
          temp_d  = mul_next[ProdBits-1:CoolBits];
          state_d = ST_CMP;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      ST_CMP: begin
        delta_d = delta;
        if (cand_lower || (delta == '0)) begin
          acc_d     = 1'b1;
          use_rom_d = 1'b0;
          state_d   = ST_FIN;
        end else if (too_far) begin
          acc_d     = 1'b0;
          use_rom_d = 1'b0;
          state_d   = ST_FIN;
        end else begin
          use_rom_d = 1'b1;
          state_d   = ST_SCALE;
        end
      end
      ST_SCALE: begin
        rem_d   = scale_prod[ScaleBits-1:IdxBits];
        lowx_d  = scale_prod[IdxBits-1:0];
        cnt_d   = CntBits'(IdxBits - 1);
        state_d = ST_DIV;
      end
      ST_DIV: begin
        // Dividend bits leave at the top of lowx while quotient bits enter below.
        rem_d  = div_ge ? div_diff[TempBits-1:0] : div_trial[TempBits-1:0];
        lowx_d = {lowx_q[IdxBits-2:0], div_ge};
        if (cnt_q == '0) begin
          state_d = ST_LOOK;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      ST_LOOK: begin
        rom_d   = exp_rom[lowx_q];
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          cur_d    = fin_cur;
          best_d   = fin_best;
          temp_d   = fin_start ? init_temp_q : temp_q;
          solved_d = fin_start ? (item_q.cost == '0) : (solved_q || (fin_best == '0));
          out_d.accepted         = fin_acc;
          out_d.new_best         = fin_improved;
          out_d.current_cost_out = fin_cur;
          out_d.best_cost_out    = fin_best;
          out_d.temperature_out  = fin_start ? init_temp_q : temp_q;
          out_d.solved           = fin_start ? (item_q.cost == '0)
                                             : (solved_q || (fin_best == '0));
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (cfg_we_i) begin
      unique case (cfg_index_i)
        aau_pkg::CFG_INITIAL_TEMPERATURE: init_temp_d = cfg_data_i[TempBits-1:0];
        aau_pkg::CFG_COOLING_FACTOR:      cool_d      = cfg_data_i[CoolBits-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      init_temp_q <= aau_pkg::INIT_TEMP_RESET;
      cool_q      <= aau_pkg::COOLING_RESET;
      cur_q       <= '0;
      best_q      <= '1;
      temp_q      <= '0;
      solved_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      init_temp_q <= init_temp_d;
      cool_q      <= cool_d;
      cur_q       <= cur_d;
      best_q      <= best_d;
      temp_q      <= temp_d;
      solved_q    <= solved_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q     <= out_d;
    item_q    <= item_d;
    p_q       <= p_d;
    cnt_q     <= cnt_d;
    delta_q   <= delta_d;
    rem_q     <= rem_d;
    lowx_q    <= lowx_d;
    rom_q     <= rom_d;
    acc_q     <= acc_d;
    use_rom_q <= use_rom_d;
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("core took a word and did not go busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_FIN))
    else $error("output word appeared without a final update");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    solved_q |-> (best_q == '0))
    else $error("solved flag set while best cost is not zero");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (rem_q < temp_q))
    else $error("divider remainder not below the temperature");
`endif

endmodule
